@@ rtl/core/crp_pkg.sv @@
// Package: relocation codes, status codes and beat types for the COFF x64 patch unit.
package crp_pkg;

  // Relocation type codes
  localparam logic [15:0] CMD_ABSOLUTE = 16'd0;
  localparam logic [15:0] CMD_ADDR64   = 16'd1;
  localparam logic [15:0] CMD_ADDR32   = 16'd2;
  localparam logic [15:0] CMD_ADDR32NB = 16'd3;
  localparam logic [15:0] CMD_REL32    = 16'd4;
  localparam logic [15:0] CMD_REL32_5  = 16'd9;
  localparam logic [15:0] CMD_SECTION  = 16'd10;
  localparam logic [15:0] CMD_SECREL   = 16'd11;
  localparam logic [15:0] CMD_SECREL7  = 16'd12;

  // Status codes
  localparam logic [2:0] ST_APPLIED     = 3'd0;
  localparam logic [2:0] ST_NOOP        = 3'd1;
  localparam logic [2:0] ST_BOUNDS      = 3'd2;
  localparam logic [2:0] ST_UNRESOLVED  = 3'd3;
  localparam logic [2:0] ST_OVF32       = 3'd4;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd5;
  localparam logic [2:0] ST_SHORT64     = 3'd6;

  // Write widths in bytes
  localparam logic [3:0] WW_NONE = 4'd0;
  localparam logic [3:0] WW_B1   = 4'd1;
  localparam logic [3:0] WW_B2   = 4'd2;
  localparam logic [3:0] WW_B4   = 4'd4;
  localparam logic [3:0] WW_B8   = 4'd8;

  localparam logic [63:0] LOAD_BASE_RST = 64'h0000_0001_4000_0000;

  typedef struct packed {
    logic [15:0]        command;
    logic [31:0]        target_rva;
    logic               symbol_found;
    logic [31:0]        site_rva;
    logic [63:0]        site_bytes;
    logic [3:0]         bytes_left;
    logic [15:0]        section_number;
    logic signed [31:0] symbol_value;
  } crp_item_t;

  typedef struct packed {
    logic [63:0] patched_bytes;
    logic [3:0]  write_width;
    logic [2:0]  status;
  } crp_result_t;

endpackage

@@ rtl/core/coff_amd64_reloc_patch.sv @@
// Top level of the x64 COFF relocation patch unit: input stage, compute, result stage.
//
// Usage:
//   Input channel (in_*): one beat per relocation, carrying the type code,
//   resolved symbol RVA and found flag, site RVA, the eight site bytes,
//   bytes left in the section, merged section index and symbol value.
//   Result channel (out_*): one beat per input beat, in order, with the
//   new site bytes, the number of bytes to write back and a status code.
//   Both channels move a beat on a rising edge with valid high, stall low.
//   Configuration: cfg_wr_en with cfg_wr_data loads the load base; write it
//   only while no beat is in flight.
//   Path: an accepted beat is held in the input register, then moves to the
//   result register, which drives the output, once that register is free.
//   Throughput: one beat per cycle while out_stall stays low; the patch math
//   is a single pass of adds and muxes between the two registers.
//   Stall: when out_stall holds the result register full, the input register
//   still takes one more beat; in_stall rises only once both stages are full.
//   Reset: clears both stage valid flags and loads the load base with
//   0x140000000; payload registers are left as they are.
module coff_amd64_reloc_patch import crp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [63:0]        cfg_wr_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_command,
  input  logic [31:0]        in_target_rva,
  input  logic               in_symbol_found,
  input  logic [31:0]        in_site_rva,
  input  logic [63:0]        in_site_bytes,
  input  logic [3:0]         in_bytes_left,
  input  logic [15:0]        in_section_number,
  input  logic signed [31:0] in_symbol_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_patched_bytes,
  output logic [3:0]         out_write_width,
  output logic [2:0]         out_status
);

  logic [63:0] load_base_r;
  logic        s1_valid_r;
  crp_item_t   s1_item_r;
  logic        out_valid_r;
  crp_result_t out_res_r;
  crp_result_t calc_res;
  logic        s2_en;
  logic        s1_en;

  // Result register frees up when empty or when its beat leaves this cycle.
  assign s2_en    = ~out_valid_r | ~out_stall;
  // Input register loads when empty or when its beat advances.
  assign s1_en    = ~s1_valid_r | s2_en;
  assign in_stall = ~s1_en;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_base_r <= LOAD_BASE_RST;
    end else if (cfg_wr_en) begin
      load_base_r <= cfg_wr_data;
    end
  end

  // Input stage: capture the beat, hold while the next stage is blocked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_item_r.command        <= in_command;
      s1_item_r.target_rva     <= in_target_rva;
      s1_item_r.symbol_found   <= in_symbol_found;
      s1_item_r.site_rva       <= in_site_rva;
      s1_item_r.site_bytes     <= in_site_bytes;
      s1_item_r.bytes_left     <= in_bytes_left;
      s1_item_r.section_number <= in_section_number;
      s1_item_r.symbol_value   <= in_symbol_value;
    end
  end

  crp_calc u_calc (
    .item      (s1_item_r),
    .load_base (load_base_r),
    .result    (calc_res)
  );

  // Result stage: advance the computed patch, hold it while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      out_res_r <= calc_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_patched_bytes = out_res_r.patched_bytes;
  assign out_write_width   = out_res_r.write_width;
  assign out_status        = out_res_r.status;

  // Back-pressure reaches the input only when both stages hold a beat.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("in_stall raised with a free stage");

  // A beat in the input stage moves to the output when the result slot frees.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_en) |=> out_valid_r)
    else $error("input stage beat lost on advance");

  // Only the defined write widths ever leave the block.
  a_width_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_write_width == WW_NONE || out_write_width == WW_B1 ||
                     out_write_width == WW_B2 || out_write_width == WW_B4 ||
                     out_write_width == WW_B8))
    else $error("illegal write width");

  // Error statuses other than overflow never write.
  a_err_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status == ST_BOUNDS || out_status == ST_UNRESOLVED ||
                     out_status == ST_UNSUPPORTED || out_status == ST_SHORT64 ||
                     out_status == ST_NOOP))
    |-> (out_write_width == WW_NONE))
    else $error("error status with a nonzero write width");

  // ADDR32 overflow still writes four bytes.
  a_ovf_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status == ST_OVF32) |-> (out_write_width == WW_B4))
    else $error("overflow status without a four-byte write");

endmodule

@@ rtl/core/crp_calc.sv @@
// Combinational patch computation for one relocation beat.
module crp_calc import crp_pkg::*; (
  input  crp_item_t   item,
  input  logic [63:0] load_base,
  output crp_result_t result
);

  logic [31:0] add32;
  logic        left_lt4;
  logic        left_full;
  logic [63:0] sum64;
  logic [63:0] sum32_ext;
  logic [31:0] nb32;
  logic [31:0] rel32;
  logic [31:0] secrel32;
  logic [7:0]  secrel7;

  assign add32     = item.site_bytes[31:0];
  // Values above eight saturate to eight, so bit 3 alone means "eight".
  assign left_full = item.bytes_left[3];
  assign left_lt4  = ~item.bytes_left[3] & ~item.bytes_left[2];

  assign sum64     = {32'd0, item.target_rva} + load_base + item.site_bytes;
  assign sum32_ext = {32'd0, item.target_rva} + load_base + {{32{add32[31]}}, add32};
  assign nb32      = item.target_rva + add32;
  // Displacement base is site + 4 + extra, and 4 + extra equals the command code.
  assign rel32     = item.target_rva - item.site_rva - {28'd0, item.command[3:0]} + add32;
  assign secrel32  = $unsigned(item.symbol_value) + add32;
  assign secrel7   = {item.site_bytes[7], item.symbol_value[6:0]};

  always_comb begin
    result.patched_bytes = item.site_bytes;
    result.write_width   = WW_NONE;
    result.status        = ST_APPLIED;
    priority if (left_lt4 && item.command != CMD_ADDR64) begin
      result.status = ST_BOUNDS;
    end else if (!item.symbol_found && item.command != CMD_ABSOLUTE) begin
      result.status = ST_UNRESOLVED;
    end else if (item.command == CMD_ABSOLUTE) begin
      result.status = ST_NOOP;
    end else if (item.command == CMD_ADDR64) begin
      if (!left_full) begin
        result.status = ST_SHORT64;
      end else begin
        result.patched_bytes = sum64;
        result.write_width   = WW_B8;
      end
    end else if (item.command == CMD_ADDR32) begin
      if (|sum32_ext[63:32]) begin
        result.status = ST_OVF32;
      end
      result.patched_bytes[31:0] = sum32_ext[31:0];
      result.write_width         = WW_B4;
    end else if (item.command == CMD_ADDR32NB) begin
      result.patched_bytes[31:0] = nb32;
      result.write_width         = WW_B4;
    end else if (item.command >= CMD_REL32 && item.command <= CMD_REL32_5) begin
      result.patched_bytes[31:0] = rel32;
      result.write_width         = WW_B4;
    end else if (item.command == CMD_SECTION) begin
      result.patched_bytes[15:0] = item.section_number;
      result.write_width         = WW_B2;
    end else if (item.command == CMD_SECREL) begin
      result.patched_bytes[31:0] = secrel32;
      result.write_width         = WW_B4;
    end else if (item.command == CMD_SECREL7) begin
      result.patched_bytes[7:0] = secrel7;
      result.write_width        = WW_B1;
    end else begin
      result.status = ST_UNSUPPORTED;
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench for coff_amd64_reloc_patch: directed and random relocations checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import crp_pkg::*;

  // Worst case is far below this: ~1200 beats, each with at most the longest
  // send gap plus the longest result stall, plus drains between phases.
  localparam int CYCLE_LIMIT = 400000;
  // Two register stages between accept and result; pad a little.
  localparam int DRAIN_CYCLES = 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_command = '0;
  logic [31:0] in_target_rva = '0;
  logic in_symbol_found = 1'b0;
  logic [31:0] in_site_rva = '0;
  logic [63:0] in_site_bytes = '0;
  logic [3:0] in_bytes_left = '0;
  logic [15:0] in_section_number = '0;
  logic signed [31:0] in_symbol_value = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] out_patched_bytes;
  logic [3:0] out_write_width;
  logic [2:0] out_status;

  // Expected result beats, oldest first, and the testbench copy of the load base.
  crp_result_t patch_q[$];
  logic [63:0] load_base_mdl = LOAD_BASE_RST;

  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  int stall_left = 0;
  bit idling_on = 1'b1;

  coff_amd64_reloc_patch dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_target_rva     (in_target_rva),
    .in_symbol_found   (in_symbol_found),
    .in_site_rva       (in_site_rva),
    .in_site_bytes     (in_site_bytes),
    .in_bytes_left     (in_bytes_left),
    .in_section_number (in_section_number),
    .in_symbol_value   (in_symbol_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_patched_bytes (out_patched_bytes),
    .out_write_width   (out_write_width),
    .out_status        (out_status)
  );

  always #10 clk = ~clk;

  // Compute the patch for one relocation. Checks run in a fixed order:
  // bounds first, then unresolved symbol, then dispatch on the type code.
  function automatic crp_result_t patch_predict(crp_item_t it, logic [63:0] base);
    crp_result_t r;
    logic [63:0] sum;
    logic [31:0] add32;
    logic [3:0] left;
    add32 = it.site_bytes[31:0];
    // bytes_left saturates at eight
    left = (it.bytes_left > 4'd8) ? 4'd8 : it.bytes_left;
    r.patched_bytes = it.site_bytes;
    r.write_width = WW_NONE;
    r.status = ST_APPLIED;
    if (left < 4'd4 && it.command != CMD_ADDR64) begin
      r.status = ST_BOUNDS;
    end else if (!it.symbol_found && it.command != CMD_ABSOLUTE) begin
      r.status = ST_UNRESOLVED;
    end else if (it.command == CMD_ABSOLUTE) begin
      r.status = ST_NOOP;
    end else if (it.command == CMD_ADDR64) begin
      if (left < 4'd8) begin
        r.status = ST_SHORT64;
      end else begin
        r.patched_bytes = {32'b0, it.target_rva} + base + it.site_bytes;
        r.write_width = WW_B8;
      end
    end else if (it.command == CMD_ADDR32) begin
      // 64-bit wrapped sum; anything above 32 bits flags overflow but is written
      sum = {32'b0, it.target_rva} + base + {{32{add32[31]}}, add32};
      if (sum[63:32] != 32'b0) r.status = ST_OVF32;
      r.patched_bytes[31:0] = sum[31:0];
      r.write_width = WW_B4;
    end else if (it.command == CMD_ADDR32NB) begin
      r.patched_bytes[31:0] = it.target_rva + add32;
      r.write_width = WW_B4;
    end else if (it.command >= CMD_REL32 && it.command <= CMD_REL32_5) begin
      r.patched_bytes[31:0] = it.target_rva
                              - (it.site_rva + 32'd4 + 32'(it.command - CMD_REL32))
                              + add32;
      r.write_width = WW_B4;
    end else if (it.command == CMD_SECTION) begin
      r.patched_bytes[15:0] = it.section_number;
      r.write_width = WW_B2;
    end else if (it.command == CMD_SECREL) begin
      r.patched_bytes[31:0] = $unsigned(it.symbol_value) + add32;
      r.write_width = WW_B4;
    end else if (it.command == CMD_SECREL7) begin
      // keep bit 7 of the first byte, replace the low seven bits
      r.patched_bytes[7:0] = {it.site_bytes[7], it.symbol_value[6:0]};
      r.write_width = WW_B1;
    end else begin
      r.status = ST_UNSUPPORTED;
    end
    return r;
  endfunction

  // Idle length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic crp_item_t mk_reloc(logic [15:0] cmd, logic [31:0] sym, logic found,
                                         logic [31:0] site, logic [63:0] bytes,
                                         logic [3:0] left, logic [15:0] sec,
                                         logic [31:0] val);
    crp_item_t it;
    it.command = cmd;
    it.target_rva = sym;
    it.symbol_found = found;
    it.site_rva = site;
    it.site_bytes = bytes;
    it.bytes_left = left;
    it.section_number = sec;
    it.symbol_value = val;
    return it;
  endfunction

  // Random relocation: mostly known types with the symbol found and the site in
  // bounds, so the patch math gets exercised; the rest hits the error paths.
  function automatic crp_item_t rand_reloc();
    crp_item_t it;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 88) it.command = 16'($urandom_range(0, 12));
    else if (roll < 95) it.command = 16'($urandom_range(13, 15));
    else it.command = 16'($urandom);
    it.target_rva = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 32'h00FF_FFFF));
    it.symbol_found = ($urandom_range(0, 9) != 0);
    it.site_rva = $urandom;
    it.site_bytes = {32'($urandom), 32'($urandom)};
    if ($urandom_range(0, 1)) it.site_bytes[31:0] = $urandom_range(0, 4095);
    it.bytes_left = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 3))
                                                : 4'($urandom_range(4, 15));
    it.section_number = 16'($urandom);
    it.symbol_value = $urandom;
    return it;
  endfunction

  // Send one relocation beat. Any idle gap goes in front of the beat; valid is
  // left high after accept so back-to-back beats need no second assignment.
  task automatic send_reloc(input crp_item_t it);
    int gap;
    gap = idling_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= it.command;
    in_target_rva <= it.target_rva;
    in_symbol_found <= it.symbol_found;
    in_site_rva <= it.site_rva;
    in_site_bytes <= it.site_bytes;
    in_bytes_left <= it.bytes_left;
    in_section_number <= it.section_number;
    in_symbol_value <= it.symbol_value;
    // hold the beat until the unit takes it
    @(posedge clk);
    while (in_stall) @(posedge clk);
    patch_q.push_back(patch_predict(it, load_base_mdl));
  endtask

  // Drop valid and wait until every expected result has come back, then let
  // the pipeline settle.
  task automatic drain_relocs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (patch_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only call while the unit is idle.
  task automatic write_load_base(input logic [63:0] base);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= base;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    load_base_mdl = base;
  endtask

  // Special cases at the reset load base.
  task automatic test_directed_cases();
    // absolute: no-op even when the symbol is missing, bounds still apply
    send_reloc(mk_reloc(CMD_ABSOLUTE, 32'h0, 1'b0, 32'h0, 64'h0, 4'd4, 16'h0, 32'h0));
    send_reloc(mk_reloc(CMD_ABSOLUTE, 32'h1, 1'b1, 32'h0, 64'h1234, 4'd3, 16'h0, 32'h0));
    // unsupported types: bounds beats unresolved beats unsupported
    send_reloc(mk_reloc(16'd13, 32'h0, 1'b1, 32'h0, 64'h0, 4'd2, 16'h0, 32'h0));
    send_reloc(mk_reloc(16'hFFFF, '1, 1'b0, '1, '1, 4'd8, '1, '1));
    send_reloc(mk_reloc(16'hFFFF, '1, 1'b1, '1, '1, 4'd8, '1, '1));
    send_reloc(mk_reloc(16'd13, 32'h10, 1'b1, 32'h20, 64'h30, 4'd15, 16'h1, 32'h1));
    send_reloc(mk_reloc(CMD_ADDR32, 32'h10, 1'b0, 32'h0, 64'h0, 4'd4, 16'h0, 32'h0));
    // addr64 skips the bounds check but needs eight bytes
    send_reloc(mk_reloc(CMD_ADDR64, 32'h10, 1'b1, 32'h0, 64'h5, 4'd0, 16'h0, 32'h0));
    send_reloc(mk_reloc(CMD_ADDR64, 32'h10, 1'b1, 32'h0, 64'h5, 4'd7, 16'h0, 32'h0));
    send_reloc(mk_reloc(CMD_ADDR64, 32'h10, 1'b0, 32'h0, 64'h5, 4'd0, 16'h0, 32'h0));
    send_reloc(mk_reloc(CMD_ADDR64, '1, 1'b1, 32'h0, '1, 4'd8, 16'h0, 32'h0));
    send_reloc(mk_reloc(CMD_ADDR64, 32'h1000, 1'b1, 32'h0, 64'h10, 4'd15, 16'h0, 32'h0));
    // addr32 with and without overflow at the reset base
    send_reloc(mk_reloc(CMD_ADDR32, 32'h1000, 1'b1, 32'h0, 64'hAAAA_BBBB_0000_0010, 4'd4,
                        16'h0, 32'h0));
    send_reloc(mk_reloc(CMD_ADDR32, 32'h100, 1'b1, 32'h0, 64'h1111_2222_8000_0000, 4'd4,
                        16'h0, 32'h0));
    send_reloc(mk_reloc(CMD_ADDR32NB, '1, 1'b1, 32'h0, 64'hFFFF_0000_0000_0001, 4'd9,
                        16'h0, 32'h0));
    // every rel32 variant
    for (int k = 0; k < 6; k++) begin
      send_reloc(mk_reloc(CMD_REL32 + 16'(k), 32'h2000, 1'b1, 32'h1000,
                          64'hDEAD_BEEF_0000_0010, 4'd4, 16'h0, 32'h0));
    end
    send_reloc(mk_reloc(CMD_SECTION, 32'h0, 1'b1, 32'h0, '1, 4'd4, 16'hFFFF, 32'h0));
    send_reloc(mk_reloc(CMD_SECTION, 32'h0, 1'b1, 32'h0, '1, 4'd8, 16'h0, 32'h0));
    send_reloc(mk_reloc(CMD_SECREL, 32'h0, 1'b1, 32'h0, 64'h5, 4'd4, 16'h0, 32'hFFFF_FFFF));
    send_reloc(mk_reloc(CMD_SECREL7, 32'h0, 1'b1, 32'h0, 64'h80, 4'd4, 16'h0,
                        32'h7FFF_FFFF));
    send_reloc(mk_reloc(CMD_SECREL7, 32'h0, 1'b1, 32'h0, 64'h7F, 4'd4, 16'h0,
                        32'h8000_0000));
    drain_relocs();
  endtask

  // Sweep the load base through its extremes, with the absolute types and a
  // random batch at each setting.
  task automatic test_load_base_extremes();
    logic [63:0] bases [5] = '{64'h0, '1, 64'h0000_0000_FFFF_FFFF,
                               64'h8000_0000_0000_0000, LOAD_BASE_RST};
    foreach (bases[b]) begin
      write_load_base(bases[b]);
      send_reloc(mk_reloc(CMD_ADDR64, '1, 1'b1, 32'h0, 64'h1, 4'd8, 16'h0, 32'h0));
      send_reloc(mk_reloc(CMD_ADDR32, 32'h1, 1'b1, 32'h0, 64'h0, 4'd4, 16'h0, 32'h0));
      send_reloc(mk_reloc(CMD_ADDR32, 32'h0, 1'b1, 32'h0, 64'hFFFF_FFFF, 4'd4, 16'h0, 32'h0));
      repeat (50) send_reloc(rand_reloc());
      drain_relocs();
    end
  endtask

  // Long random stream over several load base settings. Some phases run
  // without idling so back-to-back beats and a full pipeline get covered.
  task automatic test_random_stream();
    logic [63:0] base;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 2))
        0: base = {32'($urandom), 32'($urandom)};
        1: base = {32'b0, 32'($urandom_range(0, 32'h7FFF_FFFF))};
        default: base = 64'h0000_0000_0040_0000;
      endcase
      write_load_base(base);
      idling_on = (phase % 3 != 2);
      repeat (75) send_reloc(rand_reloc());
      // pause the sender mid-phase until every result is back
      drain_relocs();
      repeat (75) send_reloc(rand_reloc());
      drain_relocs();
    end
    idling_on = 1'b1;
  endtask

  // Result side: check each accepted beat against the oldest expectation and
  // drive out_stall with random stall runs.
  always @(posedge clk) begin : result_side
    crp_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (patch_q.size() == 0) begin
        $error("result beat with nothing pending: patched_bytes %h", out_patched_bytes);
        mismatch_cnt++;
      end else begin
        want = patch_q.pop_front();
        if (out_patched_bytes !== want.patched_bytes) begin
          $error("patched_bytes: expected %h, got %h", want.patched_bytes, out_patched_bytes);
          mismatch_cnt++;
        end
        if (out_write_width !== want.write_width) begin
          $error("write_width: expected %0d, got %0d", want.write_width, out_write_width);
          mismatch_cnt++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatch_cnt++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (!idling_on) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_load_base_extremes();
    test_random_stream();
    drain_relocs();
    if (patch_q.size() != 0) begin
      $error("%0d expected results never arrived", patch_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
